@@ rtl/pvsl_pkg.sv @@
// Shared types and constants of the planar velocity slew limiter.
package pvsl_pkg;

  localparam int LIM_WIDTH = 16;
  localparam int SPD_WIDTH = 15;

  localparam logic [1:0] CFG_STEP_XY    = 2'd0;
  localparam logic [1:0] CFG_STEP_TURN  = 2'd1;
  localparam logic [1:0] CFG_SPEED_XY   = 2'd2;
  localparam logic [1:0] CFG_SPEED_TURN = 2'd3;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_STEP = 4'b0010,
    T_SPD  = 4'b0100,
    T_OUT  = 4'b1000
  } top_state_t;

  typedef enum logic [6:0] {
    V_IDLE = 7'b0000001,
    V_SQ   = 7'b0000010,
    V_RT   = 7'b0000100,
    V_CHK  = 7'b0001000,
    V_MUL  = 7'b0010000,
    V_DIV  = 7'b0100000,
    V_DONE = 7'b1000000
  } vl_state_t;

endpackage

@@ rtl/pvsl_veclim.sv @@
// Bit-serial vector length limiter: square, root, scale by lim/len when len exceeds lim.
module pvsl_veclim #(
  parameter int W = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [W:0]               a_i,
  input  logic signed [W:0]               b_i,
  input  logic [pvsl_pkg::LIM_WIDTH-1:0]  lim_i,
  output logic                            done_o,
  output logic signed [W:0]               ra_o,
  output logic signed [W:0]               rb_o
);
  import pvsl_pkg::*;

  localparam int SW  = 2 * (W + 1);
  localparam int PW  = W + 1 + LIM_WIDTH;
  localparam int RW  = W + 3;
  localparam int CNW = $clog2(PW);
  localparam int LW  = ((W + 1) > LIM_WIDTH) ? (W + 1) : LIM_WIDTH;

  vl_state_t state_r, state_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic sa_r, sa_nxt, sb_r, sb_nxt;
  logic [W:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic [W:0] mqa_r, mqa_nxt, mqb_r, mqb_nxt;
  logic [SW-1:0] mca_r, mca_nxt, mcb_r, mcb_nxt, acc_r, acc_nxt;
  logic [LIM_WIDTH-1:0] lim_r, lim_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [W:0] root_r, root_nxt;
  logic [PW-1:0] pa_r, pa_nxt, pb_r, pb_nxt, mua_r, mua_nxt, mub_r, mub_nxt;
  logic [W:0] dra_r, dra_nxt, drb_r, drb_nxt;
  logic signed [W:0] ra_r, ra_nxt, rb_r, rb_nxt;

  logic [RW+1:0] rt_t, rt_trial;
  logic [W+1:0] da_t, db_t;
  logic da_ge, db_ge;

  always_comb begin
    rt_t     = {rem_r, acc_r[SW-1:SW-2]};
    rt_trial = {1'b0, root_r, 2'b01};
    da_t     = {dra_r, pa_r[PW-1]};
    db_t     = {drb_r, pb_r[PW-1]};
    da_ge    = da_t >= {1'b0, root_r};
    db_ge    = db_t >= {1'b0, root_r};
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sa_nxt = sa_r; sb_nxt = sb_r;
    ma_nxt = ma_r; mb_nxt = mb_r;
    mqa_nxt = mqa_r; mqb_nxt = mqb_r;
    mca_nxt = mca_r; mcb_nxt = mcb_r;
    acc_nxt = acc_r;
    lim_nxt = lim_r;
    rem_nxt = rem_r; root_nxt = root_r;
    pa_nxt = pa_r; pb_nxt = pb_r;
    mua_nxt = mua_r; mub_nxt = mub_r;
    dra_nxt = dra_r; drb_nxt = drb_r;
    ra_nxt = ra_r; rb_nxt = rb_r;
    unique case (state_r)
      // a new pass may start in the done cycle of the previous one
      V_IDLE, V_DONE: begin
        state_nxt = V_IDLE;
        if (start) begin
          sa_nxt  = a_i[W];
          sb_nxt  = b_i[W];
          ma_nxt  = a_i[W] ? -a_i : a_i;
          mb_nxt  = b_i[W] ? -b_i : b_i;
          mqa_nxt = a_i[W] ? -a_i : a_i;
          mqb_nxt = b_i[W] ? -b_i : b_i;
          mca_nxt = {{(SW-W-1){1'b0}}, (a_i[W] ? -a_i : a_i)};
          mcb_nxt = {{(SW-W-1){1'b0}}, (b_i[W] ? -b_i : b_i)};
          acc_nxt = '0;
          lim_nxt = lim_i;
          cnt_nxt = CNW'(W);
          state_nxt = V_SQ;
        end
      end
      V_SQ: begin
        // shift-add squares of both magnitudes, one multiplier bit a cycle
        acc_nxt = acc_r + (mqa_r[0] ? mca_r : '0) + (mqb_r[0] ? mcb_r : '0);
        mqa_nxt = mqa_r >> 1;
        mqb_nxt = mqb_r >> 1;
        mca_nxt = mca_r << 1;
        mcb_nxt = mcb_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          rem_nxt  = '0;
          root_nxt = '0;
          cnt_nxt  = CNW'(W);
          state_nxt = V_RT;
        end
      end
      V_RT: begin
        // one root bit per cycle, two radicand bits consumed
        acc_nxt = acc_r << 2;
        if (rt_t >= rt_trial) begin
          rem_nxt  = RW'(rt_t - rt_trial);
          root_nxt = {root_r[W-1:0], 1'b1};
        end else begin
          rem_nxt  = rt_t[RW-1:0];
          root_nxt = {root_r[W-1:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = V_CHK;
      end
      V_CHK: begin
        if (LW'(root_r) > LW'(lim_r)) begin
          pa_nxt  = '0;
          pb_nxt  = '0;
          mua_nxt = PW'(ma_r);
          mub_nxt = PW'(mb_r);
          cnt_nxt = CNW'(LIM_WIDTH - 1);
          state_nxt = V_MUL;
        end else begin
          ra_nxt = sa_r ? -ma_r : ma_r;
          rb_nxt = sb_r ? -mb_r : mb_r;
          state_nxt = V_DONE;
        end
      end
      V_MUL: begin
        pa_nxt  = pa_r + (lim_r[0] ? mua_r : '0);
        pb_nxt  = pb_r + (lim_r[0] ? mub_r : '0);
        mua_nxt = mua_r << 1;
        mub_nxt = mub_r << 1;
        lim_nxt = lim_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          dra_nxt = '0;
          drb_nxt = '0;
          cnt_nxt = CNW'(PW - 1);
          state_nxt = V_DIV;
        end
      end
      V_DIV: begin
        // restoring divide by the length; quotient shifts into the product
        pa_nxt  = {pa_r[PW-2:0], da_ge};
        pb_nxt  = {pb_r[PW-2:0], db_ge};
        dra_nxt = da_ge ? (W+1)'(da_t - {1'b0, root_r}) : da_t[W:0];
        drb_nxt = db_ge ? (W+1)'(db_t - {1'b0, root_r}) : db_t[W:0];
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = V_DONE;
      end
      default: state_nxt = V_IDLE;
    endcase
    if (state_r == V_DIV && cnt_r == '0) begin
      ra_nxt = sa_r ? -pa_nxt[W:0] : pa_nxt[W:0];
      rb_nxt = sb_r ? -pb_nxt[W:0] : pb_nxt[W:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= V_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r <= cnt_nxt;
    sa_r <= sa_nxt; sb_r <= sb_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt;
    mqa_r <= mqa_nxt; mqb_r <= mqb_nxt;
    mca_r <= mca_nxt; mcb_r <= mcb_nxt;
    acc_r <= acc_nxt;
    lim_r <= lim_nxt;
    rem_r <= rem_nxt; root_r <= root_nxt;
    pa_r <= pa_nxt; pb_r <= pb_nxt;
    mua_r <= mua_nxt; mub_r <= mub_nxt;
    dra_r <= dra_nxt; drb_r <= drb_nxt;
    ra_r <= ra_nxt; rb_r <= rb_nxt;
  end

  assign done_o = (state_r == V_DONE);
  assign ra_o   = ra_r;
  assign rb_o   = rb_r;

endmodule

@@ rtl/planar_velocity_slew_limiter.sv @@
// Processing: each item takes two passes of the vector unit (step limit, then speed limit);
//   a pass runs square, root and compare, plus multiply and divide when it scales. The
//   result then loads the output register, which raises out_valid.
// Throughput: one item at a time, set by the bit-serial square, root, multiply and divide;
//   in_stall stays high from the input transfer until the result loads the output register.
// A new transfer is taken while the previous result still waits in the output register.
// Reset (synchronous, rst_n low): limits to maximum, last velocity to zero.
module planar_velocity_slew_limiter #(
  parameter int VEL_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [VEL_WIDTH-1:0]         in_cmd_vel_x,
  input  logic signed [VEL_WIDTH-1:0]         in_cmd_vel_y,
  input  logic signed [VEL_WIDTH-1:0]         in_cmd_turn_rate,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [VEL_WIDTH-1:0]         out_vel_x,
  output logic signed [VEL_WIDTH-1:0]         out_vel_y,
  output logic signed [VEL_WIDTH-1:0]         out_turn_rate,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [pvsl_pkg::LIM_WIDTH-1:0]      cfg_data
);
  import pvsl_pkg::*;

  localparam int W  = VEL_WIDTH;
  localparam int CW = (((W + 1) > LIM_WIDTH) ? (W + 1) : LIM_WIDTH) + 1;

  top_state_t state_r, state_nxt;
  logic [LIM_WIDTH-1:0] step_xy_r, step_t_r;
  logic [SPD_WIDTH-1:0] spd_xy_r, spd_t_r;
  logic signed [W-1:0] px_r, px_nxt, py_r, py_nxt, pt_r, pt_nxt;
  logic signed [W:0] dtc_r, dtc_nxt;
  logic signed [W-1:0] vt_r, vt_nxt;
  logic signed [W-1:0] ox_r, oy_r, ot_r;
  logic out_valid_r;

  logic vl_start;
  logic signed [W:0] vl_a, vl_b, vl_ra, vl_rb;
  logic [LIM_WIDTH-1:0] vl_lim;
  logic vl_done;

  logic signed [W:0] dt, vt_sum;
  logic signed [CW-1:0] dte, vte, lse, lve;
  logic signed [W:0] vx_sum, vy_sum;
  logic in_xfer, out_load;

  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state_r == T_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    dt     = {in_cmd_turn_rate[W-1], in_cmd_turn_rate} - {pt_r[W-1], pt_r};
    dte    = {{(CW-W-1){dt[W]}}, dt};
    lse    = {{(CW-LIM_WIDTH){1'b0}}, step_t_r};
    dtc_nxt = dtc_r;
    if (in_xfer) begin
      if (dte > lse) dtc_nxt = lse[W:0];
      else if (dte < -lse) dtc_nxt = (W+1)'(-lse);
      else dtc_nxt = dt;
    end
    vt_sum = {pt_r[W-1], pt_r} + dtc_r;
    vte    = {{(CW-W-1){vt_sum[W]}}, vt_sum};
    lve    = {{(CW-SPD_WIDTH){1'b0}}, spd_t_r};
    vx_sum = {px_r[W-1], px_r} + vl_ra;
    vy_sum = {py_r[W-1], py_r} + vl_rb;
    vt_nxt = vt_r;
    if (state_r == T_STEP && vl_done) begin
      if (vte > lve) vt_nxt = lve[W-1:0];
      else if (vte < -lve) vt_nxt = W'(-lve);
      else vt_nxt = vt_sum[W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    vl_start  = 1'b0;
    vl_a      = {in_cmd_vel_x[W-1], in_cmd_vel_x} - {px_r[W-1], px_r};
    vl_b      = {in_cmd_vel_y[W-1], in_cmd_vel_y} - {py_r[W-1], py_r};
    vl_lim    = step_xy_r;
    px_nxt = px_r; py_nxt = py_r; pt_nxt = pt_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_valid) begin
          vl_start  = 1'b1;
          state_nxt = T_STEP;
        end
      end
      T_STEP: begin
        vl_a   = {vx_sum[W-1], vx_sum[W-1:0]};
        vl_b   = {vy_sum[W-1], vy_sum[W-1:0]};
        vl_lim = {{(LIM_WIDTH-SPD_WIDTH){1'b0}}, spd_xy_r};
        if (vl_done) begin
          vl_start  = 1'b1;
          state_nxt = T_SPD;
        end
      end
      T_SPD: begin
        if (vl_done) begin
          px_nxt = vl_ra[W-1:0];
          py_nxt = vl_rb[W-1:0];
          pt_nxt = vt_r;
          state_nxt = T_OUT;
        end
      end
      T_OUT: begin
        if (out_load) state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  pvsl_veclim #(.W(W)) u_veclim (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (vl_start),
    .a_i    (vl_a),
    .b_i    (vl_b),
    .lim_i  (vl_lim),
    .done_o (vl_done),
    .ra_o   (vl_ra),
    .rb_o   (vl_rb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      step_xy_r   <= '1;
      step_t_r    <= '1;
      spd_xy_r    <= '1;
      spd_t_r     <= '1;
      px_r        <= '0;
      py_r        <= '0;
      pt_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      pt_r    <= pt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEP_XY:    step_xy_r <= cfg_data;
          CFG_STEP_TURN:  step_t_r  <= cfg_data;
          CFG_SPEED_XY:   spd_xy_r  <= cfg_data[SPD_WIDTH-1:0];
          CFG_SPEED_TURN: spd_t_r   <= cfg_data[SPD_WIDTH-1:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    dtc_r <= dtc_nxt;
    vt_r  <= vt_nxt;
    if (out_load) begin
      ox_r <= px_r;
      oy_r <= py_r;
      ot_r <= pt_r;
    end
  end

  assign in_stall      = (state_r != T_IDLE);
  assign out_valid     = out_valid_r;
  assign out_vel_x     = ox_r;
  assign out_vel_y     = oy_r;
  assign out_turn_rate = ot_r;

endmodule

@@ sim/planar_velocity_slew_limiter_test.sv @@
// Self-checking testbench of the planar velocity slew limiter.
`timescale 1ns / 100ps

module planar_velocity_slew_limiter_test;
  import pvsl_pkg::*;

  localparam int VW = 16;

  typedef struct packed {
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [VW-1:0] vt;
  } velocity_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VW-1:0] in_cmd_vel_x = '0;
  logic signed [VW-1:0] in_cmd_vel_y = '0;
  logic signed [VW-1:0] in_cmd_turn_rate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VW-1:0] out_vel_x, out_vel_y, out_turn_rate;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_STEP_XY;
  logic [LIM_WIDTH-1:0] cfg_data = '0;

  planar_velocity_slew_limiter #(.VEL_WIDTH(VW)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd_vel_x(in_cmd_vel_x), .in_cmd_vel_y(in_cmd_vel_y),
    .in_cmd_turn_rate(in_cmd_turn_rate),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_turn_rate(out_turn_rate),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // limits and last velocity as the block should hold them
  longint lim_step_xy, lim_step_turn, lim_speed_xy, lim_speed_turn;
  longint last_x, last_y, last_t;

  velocity_t cmd_queue[$];
  velocity_t expected_vel[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int cfg_writes = 0;
  bit hold_off = 1'b0;
  bit long_hold = 1'b0;

  function automatic longint floor_hypot(longint a, longint b);
    longint sum, r;
    sum = a * a + b * b;
    r = 0;
    for (int bit_i = 17; bit_i >= 0; bit_i--)
      if ((r + (64'sd1 << bit_i)) * (r + (64'sd1 << bit_i)) <= sum)
        r = r + (64'sd1 << bit_i);
    return r;
  endfunction

  function automatic longint shrink(longint d, longint num, longint den);
    longint q;
    q = (d < 0 ? -d : d) * num / den;
    return d < 0 ? -q : q;
  endfunction

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void fit_length(ref longint a, ref longint b, input longint lim);
    longint len;
    len = floor_hypot(a, b);
    if (len > lim) begin
      a = shrink(a, lim, len);
      b = shrink(b, lim, len);
    end
  endfunction

  function automatic velocity_t limit_velocity(velocity_t c);
    longint dx, dy, dt, nx, ny, nt;
    velocity_t r;
    dx = longint'(c.vx) - last_x;
    dy = longint'(c.vy) - last_y;
    dt = clamp_mag(longint'(c.vt) - last_t, lim_step_turn);
    fit_length(dx, dy, lim_step_xy);
    nx = last_x + dx;
    ny = last_y + dy;
    nt = clamp_mag(last_t + dt, lim_speed_turn);
    fit_length(nx, ny, lim_speed_xy);
    last_x = nx;
    last_y = ny;
    last_t = nt;
    r.vx = nx[VW-1:0];
    r.vy = ny[VW-1:0];
    r.vt = nt[VW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s at result %0d: got %0d want %0d", what, checked, got, want);
    errors++;
  endtask

  // driver: random gap per item, valid held while stalled
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_vel.push_back(limit_velocity({in_cmd_vel_x, in_cmd_vel_y, in_cmd_turn_rate}));
        sent++;
        gap <= $urandom_range(0, 13);
      end
      if (!(in_valid && in_stall)) begin
        if (in_valid && !in_stall && $urandom_range(0, 3) != 0) begin
          in_valid <= 1'b0;
        end else if (!(in_valid && !in_stall) && gap > 0) begin
          gap <= gap - 1;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0 && !hold_off) begin
          velocity_t c;
          c = cmd_queue.pop_front();
          in_cmd_vel_x <= c.vx;
          in_cmd_vel_y <= c.vy;
          in_cmd_turn_rate <= c.vt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor with random receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_vel.size() == 0) begin
          $display("unexpected result at %0d", checked);
          errors++;
        end else begin
          velocity_t e;
          e = expected_vel.pop_front();
          if (out_vel_x !== e.vx)
            report_mismatch("vel_x", longint'(out_vel_x), longint'(e.vx));
          if (out_vel_y !== e.vy)
            report_mismatch("vel_y", longint'(out_vel_y), longint'(e.vy));
          if (out_turn_rate !== e.vt)
            report_mismatch("turn_rate", longint'(out_turn_rate), longint'(e.vt));
        end
        checked++;
        stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else if (long_hold) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || in_valid || expected_vel.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [LIM_WIDTH-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_STEP_XY:    lim_step_xy = longint'(value);
      CFG_STEP_TURN:  lim_step_turn = longint'(value);
      CFG_SPEED_XY:   lim_speed_xy = longint'(value[SPD_WIDTH-1:0]);
      default:        lim_speed_turn = longint'(value[SPD_WIDTH-1:0]);
    endcase
    cfg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [VW-1:0] rand_vel();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return VW'($urandom_range(0, 200) - 100);
      default: return VW'($urandom());
    endcase
  endfunction

  task automatic push_cmd(longint x, longint y, longint t);
    velocity_t c;
    c.vx = x[VW-1:0];
    c.vy = y[VW-1:0];
    c.vt = t[VW-1:0];
    cmd_queue.push_back(c);
  endtask

  initial begin
    lim_step_xy = 65535;
    lim_step_turn = 65535;
    lim_speed_xy = 32767;
    lim_speed_turn = 32767;
    last_x = 0;
    last_y = 0;
    last_t = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero change, extremes, lengths exactly at a limit
    push_cmd(0, 0, 0);
    push_cmd(32767, 32767, 32767);
    push_cmd(-32768, -32768, -32768);
    push_cmd(-32768, 32767, 0);
    push_cmd(3, 4, 5);
    wait_drained();
    write_limit(CFG_STEP_XY, 5);
    write_limit(CFG_STEP_TURN, 7);
    write_limit(CFG_SPEED_XY, 100);
    write_limit(CFG_SPEED_TURN, 20);
    push_cmd(3, 4, 7);
    push_cmd(3, 4, 7);
    push_cmd(600, -800, -30000);
    push_cmd(-32768, 32767, 32767);
    push_cmd(0, 0, 0);
    wait_drained();
    write_limit(CFG_STEP_XY, 0);
    write_limit(CFG_STEP_TURN, 0);
    push_cmd(1000, 1000, 1000);
    push_cmd(-1, -1, -1);
    wait_drained();
    write_limit(CFG_STEP_XY, 16'hffff);
    write_limit(CFG_STEP_TURN, 16'hffff);
    write_limit(CFG_SPEED_XY, 0);
    write_limit(CFG_SPEED_TURN, 0);
    push_cmd(-32768, 32767, -32768);
    push_cmd(5, 5, 5);
    wait_drained();

    // random phases through several limit settings
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_limit(CFG_SPEED_XY, 16'hffff);
          write_limit(CFG_SPEED_TURN, 16'hffff);
        end
        7: begin
          write_limit(CFG_STEP_XY, 16'hffff);
          write_limit(CFG_STEP_TURN, 16'hffff);
          write_limit(CFG_SPEED_XY, 16'h7fff);
          write_limit(CFG_SPEED_TURN, 16'h7fff);
        end
        default: begin
          write_limit(CFG_STEP_XY, LIM_WIDTH'($urandom_range(0, 3) == 0 ?
                                               $urandom() : $urandom_range(0, 3000)));
          write_limit(CFG_STEP_TURN, LIM_WIDTH'($urandom_range(0, 3) == 0 ?
                                                 $urandom() : $urandom_range(0, 3000)));
          write_limit(CFG_SPEED_XY, LIM_WIDTH'($urandom()));
          write_limit(CFG_SPEED_TURN, LIM_WIDTH'($urandom()));
        end
      endcase
      for (int k = 0; k < 210; k++)
        push_cmd(longint'(rand_vel()), longint'(rand_vel()), longint'(rand_vel()));
      if (phase == 3) begin
        // receiver holds off while items keep coming, block backs up
        long_hold = 1'b1;
        repeat (2000) @(posedge clk);
        long_hold = 1'b0;
      end
      if (phase == 5) begin
        // sender pauses until all results are back
        while (cmd_queue.size() > 100) @(posedge clk);
        hold_off = 1'b1;
        while (in_valid || expected_vel.size() > 0) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_drained();
    end

    $display("covered %0d transfers, %0d results, %0d limit writes over 8 random phases",
             sent, checked, cfg_writes);
    if (errors == 0) $display("PASS planar_velocity_slew_limiter");
    else $display("FAIL planar_velocity_slew_limiter");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL planar_velocity_slew_limiter");
    $finish;
  end

endmodule
